/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl, sampled on clk and quiet during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/swfn_pkg.sv */
package swfn_pkg;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int CFG_W = 11;

  // default store depth and largest window
  localparam int WINDOW_MAX_DEF = 1024;

  // operations requested of the negative-sample queue for one request
  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } queue_op_t;

  // queue status seen by the control logic
  typedef struct packed {
    logic front_valid;
    logic full;
  } queue_stat_t;

endpackage

/* rtl/swfn_queue.sv */
module swfn_queue import swfn_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  localparam int POS_W = $clog2(2 * WINDOW_MAX)
) (
  input  logic              clk,
  input  logic              rst,
  input  queue_op_t         op,
  input  logic [POS_W-1:0]  push_pos,
  input  logic [DATA_W-1:0] push_val,
  output logic [POS_W-1:0]  front_pos,
  output queue_stat_t       stat,
  output logic [DATA_W-1:0] head_val
);

  localparam int ENT_W = POS_W + DATA_W;
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  // the three oldest entries live in registers, the rest in the memory;
  // the third one may still sit in the memory read register (src2)
  logic [ENT_W-1:0] r0, r1, r2;
  logic             v0, v1, v2, src2;
  logic [AW-1:0]    mrd, mwr;
  logic [CNT_W-1:0] mcnt, cnt;
  logic [ENT_W-1:0] mem [WINDOW_MAX];
  logic [ENT_W-1:0] rdata;

  logic [ENT_W-1:0] e2, pe;
  logic [ENT_W-1:0] a0, a1;
  logic             av0, av1, av2;
  logic             rd_en, wr_en;
  logic [ENT_W-1:0] r0_next, r1_next, r2_next;
  logic             v0_next, v1_next, v2_next, src2_next;
  logic [ENT_W-1:0] f0;

  assign e2 = src2 ? rdata : r2;
  assign pe = {push_pos, push_val};

  // pop, refill from the memory, then place the pushed entry
  always_comb begin
    rd_en = 1'b0;
    wr_en = 1'b0;
    src2_next = src2;
    r2_next = r2;
    if (op.pop) begin
      a0 = r1;
      av0 = v1;
      a1 = e2;
      av1 = v2;
      rd_en = (mcnt != '0);
      av2 = rd_en;
      src2_next = rd_en;
    end else begin
      a0 = r0;
      av0 = v0;
      a1 = r1;
      av1 = v1;
      av2 = v2;
    end
    r0_next = a0;
    v0_next = av0;
    r1_next = a1;
    v1_next = av1;
    v2_next = av2;
    if (op.push) begin
      if (!av0) begin
        r0_next = pe;
        v0_next = 1'b1;
      end else if (!av1) begin
        r1_next = pe;
        v1_next = 1'b1;
      end else if (!av2) begin
        r2_next = pe;
        v2_next = 1'b1;
        src2_next = 1'b0;
      end else begin
        wr_en = 1'b1;
      end
    end
  end

  // head after this request's pop and push
  always_comb begin
    if (av0) begin
      f0 = a0;
    end else if (op.push) begin
      f0 = pe;
    end else begin
      f0 = '0;
    end
  end

  assign head_val = f0[DATA_W-1:0];
  assign front_pos = r0[ENT_W-1:DATA_W];
  assign stat.front_valid = v0;
  assign stat.full = (cnt == CNT_W'(WINDOW_MAX));

  // register entries and memory pointers
  always_ff @(posedge clk) begin
    if (rst || op.clear) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      src2 <= 1'b0;
      mrd <= '0;
      mwr <= '0;
      mcnt <= '0;
      cnt <= '0;
    end else begin
      v0 <= v0_next;
      v1 <= v1_next;
      v2 <= v2_next;
      src2 <= src2_next;
      if (rd_en) begin
        mrd <= (mrd == AW'(WINDOW_MAX - 1)) ? '0 : mrd + 1'b1;
      end
      if (wr_en) begin
        mwr <= (mwr == AW'(WINDOW_MAX - 1)) ? '0 : mwr + 1'b1;
      end
      mcnt <= mcnt - CNT_W'(rd_en) + CNT_W'(wr_en);
      cnt <= cnt - CNT_W'(op.pop) + CNT_W'(op.push);
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    r0 <= r0_next;
    r1 <= r1_next;
    r2 <= r2_next;
  end

  // overflow memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mwr] <= pe;
    end
    if (rd_en) begin
      rdata <= mem[mrd];
    end
  end

endmodule

/* rtl/sliding_window_first_negative_core.sv */
// First negative sample in a sliding window. Samples arrive on s_axis, one per
// request, with tlast marking the end of a sequence. Once window_size samples
// of the sequence have been seen, every sample yields one result on m_axis:
// the oldest negative sample still inside the window, or 0 if there is none.
// A sequence that ends before the window fills yields one result at its last
// sample; m_axis_tlast marks the final result of each sequence, after which
// all counters restart. The user must write window_size through the cfg port
// only while the block is idle; the block itself does not enforce this. 0 acts
// as 1 and values above WINDOW_MAX act as WINDOW_MAX. Throughput is one sample
// per clock while the skid register is empty: the queue of negative samples
// keeps its three oldest entries in registers and prefetches the next one from
// its memory, so a drop and an append both finish in the cycle of the request.
// Results are registered onto m_axis; a skid register holds one more result
// when m_axis stalls, keeping s_axis_tready low. No clearing pass after reset.
`include "assert_macros.svh"

module sliding_window_first_negative_core import swfn_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration: window_size
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  // samples
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] sample_value
  input  logic              s_axis_tlast,   // end_of_sequence
  // results
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] first_negative
  output logic              m_axis_tlast    // last_result
);

  localparam int POS_W = $clog2(2 * WINDOW_MAX);
  localparam int WIN_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (WIN_W > CFG_W) ? WIN_W : CFG_W;
  localparam int POS_MOD = 2 * WINDOW_MAX;

  logic [WIN_W-1:0]  win;
  logic [POS_W-1:0]  pos;
  logic [WIN_W-1:0]  seen;
  logic              skid_valid;
  logic [DATA_W-1:0] skid_data;
  logic              skid_last;

  logic              in_acc;
  logic [POS_W-1:0]  front_pos;
  queue_stat_t       stat;
  queue_op_t         op;
  logic [DATA_W-1:0] head_val;
  logic [POS_W:0]    diff;
  logic [POS_W-1:0]  age;
  logic              stale;
  logic [WIN_W-1:0]  seen_next;
  logic [POS_W-1:0]  pos_next;
  logic              emit;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // effective window, clamped at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= WIN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data == '0) begin
        win <= WIN_W'(1);
      end else if (CMP_W'(cfg_data) > CMP_W'(WINDOW_MAX)) begin
        win <= WIN_W'(WINDOW_MAX);
      end else begin
        win <= WIN_W'(cfg_data);
      end
    end
  end

  // age of the oldest stored negative, modulo the position range
  assign diff = {1'b0, pos} - {1'b0, front_pos};
  assign age = diff[POS_W] ? POS_W'(diff + (POS_W + 1)'(POS_MOD)) : diff[POS_W-1:0];
  assign stale = stat.front_valid && (age >= POS_W'(win));

  // queue operations for this request
  always_comb begin
    op.pop = in_acc && stale;
    op.push = in_acc && s_axis_tdata[DATA_W-1] && (!stat.full || op.pop);
    op.clear = in_acc && s_axis_tlast;
  end

  swfn_queue #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .push_pos (pos),
    .push_val (s_axis_tdata),
    .front_pos(front_pos),
    .stat     (stat),
    .head_val (head_val)
  );

  // sequence counters
  assign seen_next = (seen < win) ? seen + 1'b1 : win;
  assign pos_next = (pos == POS_W'(POS_MOD - 1)) ? '0 : pos + 1'b1;
  assign emit = in_acc && ((seen_next >= win) || s_axis_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      seen <= '0;
    end else if (in_acc) begin
      pos <= s_axis_tlast ? '0 : pos_next;
      seen <= s_axis_tlast ? '0 : seen_next;
    end
  end

  // output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!emit) begin
        m_axis_tvalid <= 1'b0;
      end
    end else if (emit) begin
      if (m_axis_tvalid) begin
        skid_valid <= 1'b1;
      end else begin
        m_axis_tvalid <= 1'b1;
      end
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tdata <= skid_data;
        m_axis_tlast <= skid_last;
      end else if (emit) begin
        m_axis_tdata <= head_val;
        m_axis_tlast <= s_axis_tlast;
      end
    end else if (emit) begin
      if (m_axis_tvalid) begin
        skid_data <= head_val;
        skid_last <= s_axis_tlast;
      end else begin
        m_axis_tdata <= head_val;
        m_axis_tlast <= s_axis_tlast;
      end
    end
  end

  // checks
  `ASSERT_IMPLIES(a_skid_behind_out, skid_valid, m_axis_tvalid)
  `ASSERT_NEXT(a_result_shown, emit, m_axis_tvalid)
  `ASSERT_NEXT(a_eos_clears, in_acc && s_axis_tlast, (seen == '0) && (pos == '0))

endmodule
